/* rtl/rfc_pkg.sv */
package rfc_pkg;

  // captured header and data bytes of a frame
  localparam int CapDepth = 10;

  // result codes
  localparam logic [2:0] RES_OK          = 3'd0;
  localparam logic [2:0] RES_INVALID     = 3'd1;
  localparam logic [2:0] RES_UNIT_BADSUM = 3'd2;
  localparam logic [2:0] RES_UNIT_BADCMD = 3'd3;
  localparam logic [2:0] RES_SUM_MISMATCH = 3'd4;

  // frame byte codes
  localparam logic [7:0] START_BYTE     = 8'hCA;
  localparam logic [7:0] UNIT_ERROR     = 8'h0F;
  localparam logic [7:0] SCALE_TEN_A    = 8'h10;
  localparam logic [7:0] SCALE_TEN_B    = 8'h11;
  localparam logic [7:0] SCALE_HUND_A   = 8'h20;
  localparam logic [7:0] SCALE_HUND_B   = 8'h21;
  localparam logic [7:0] CMD_STATUS     = 8'h09;
  localparam logic [7:0] CMD_ONOFF      = 8'h81;
  localparam logic [7:0] ERR_BAD_CMD    = 8'h01;
  localparam logic [7:0] ERR_BAD_SUM    = 8'h03;
  localparam logic [7:0] MAX_DATA_COUNT = 8'd8;
  localparam logic [7:0] COUNT_READING  = 8'd3;
  localparam logic [7:0] COUNT_STATUS   = 8'd5;

  // frame state seen by the decoder
  typedef struct packed {
    logic [CapDepth-1:0][7:0] bytes;
    logic [7:0]               command;
    logic [7:0]               sum;
    logic [3:0]               avail_cnt;  // bytes before current one, capped at CapDepth
    logic                     too_long;
  } rfc_frame_t;

  // one result
  typedef struct packed {
    logic [2:0]  result_code;
    logic [15:0] reading_value;
    logic [1:0]  reading_scale;
    logic        is_status_reply;
    logic [39:0] status_bits;
  } rfc_result_t;

endpackage

/* rtl/rfc_rx_if.sv */
interface rfc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  logic [7:0] expected_command;

  modport source (output valid, output rx_byte, output frame_end,
                  output expected_command, input ready);
  modport sink (input valid, input rx_byte, input frame_end,
                input expected_command, output ready);
endinterface

/* rtl/rfc_result_if.sv */
interface rfc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_code;
  logic [15:0] reading_value;
  logic [1:0]  reading_scale;
  logic        is_status_reply;
  logic [39:0] status_bits;

  modport source (output valid, output result_code, output reading_value,
                  output reading_scale, output is_status_reply, output status_bits,
                  input ready);
  modport sink (input valid, input result_code, input reading_value,
                input reading_scale, input is_status_reply, input status_bits,
                output ready);
endinterface

/* rtl/rfc_frame_track.sv */
module rfc_frame_track
  import rfc_pkg::*;
#(
  parameter int MaxFrameBytes = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  input  logic [7:0] expected_command,
  output rfc_frame_t frame
);

  localparam int PosWidth = $clog2(MaxFrameBytes + 1);

  logic [PosWidth-1:0]      byte_position;
  logic [7:0]               running_sum;
  logic [7:0]               latched_command;
  logic [CapDepth-1:0][7:0] captured_bytes;

  // position, sum and command latch
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      running_sum     <= '0;
      latched_command <= '0;
    end else if (accept) begin
      if (byte_position == '0) begin
        latched_command <= expected_command;
      end
      if (frame_end) begin
        byte_position <= '0;
        running_sum   <= '0;
      end else begin
        if (byte_position != '0) begin
          running_sum <= running_sum + rx_byte;
        end
        if (byte_position < PosWidth'(MaxFrameBytes)) begin
          byte_position <= byte_position + 1'b1;
        end
      end
    end
  end

  // capture of the leading frame bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < CapDepth; k++) begin
        if (int'(byte_position) == k) begin
          captured_bytes[k] <= rx_byte;
        end
      end
    end
  end

  // view for the decoder
  always_comb begin
    frame.bytes     = captured_bytes;
    frame.command   = (byte_position == '0) ? expected_command : latched_command;
    frame.sum       = running_sum;
    frame.avail_cnt = (int'(byte_position) >= CapDepth) ? 4'(CapDepth)
                                                         : 4'(byte_position);
    frame.too_long  = (byte_position >= PosWidth'(MaxFrameBytes));
  end

endmodule

/* rtl/rfc_decode.sv */
module rfc_decode
  import rfc_pkg::*;
(
  input  rfc_frame_t  frame,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  unit_address,
  output rfc_result_t result
);

  logic [CapDepth-1:0][7:0] b;
  logic [7:0]               cmd;
  logic                     value_cmd;

  assign b   = frame.bytes;
  assign cmd = frame.command;

  // byte i lies before the checksum byte
  function automatic logic avail(input logic [3:0] cnt, input int i);
    return cnt > 4'(i);
  endfunction

  // read and set commands that answer with a reading
  always_comb begin
    unique case (cmd)
      8'h20, 8'h21, 8'h70, 8'h40, 8'h60,
      8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76,
      8'hF0, 8'hC0, 8'hE0,
      8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6: value_cmd = 1'b1;
      default:                                   value_cmd = 1'b0;
    endcase
  end

  // checks in order of precedence
  always_comb begin
    result             = '0;
    result.result_code = RES_INVALID;
    priority if (frame.too_long) begin
      result.result_code = RES_INVALID;
    end else if (~frame.sum != rx_byte) begin
      result.result_code = RES_SUM_MISMATCH;
    end else if (!avail(frame.avail_cnt, 2) || b[0] != START_BYTE || b[1] != 8'h00 ||
                 b[2] != unit_address || !avail(frame.avail_cnt, 3)) begin
      result.result_code = RES_INVALID;
    end else if (b[3] == UNIT_ERROR) begin
      if (avail(frame.avail_cnt, 5)) begin
        if (b[5] == ERR_BAD_CMD) begin
          result.result_code = RES_UNIT_BADCMD;
        end else if (b[5] == ERR_BAD_SUM) begin
          result.result_code = RES_UNIT_BADSUM;
        end
      end
    end else if (b[3] != cmd || !avail(frame.avail_cnt, 4) || b[4] > MAX_DATA_COUNT) begin
      result.result_code = RES_INVALID;
    end else if (value_cmd) begin
      if (b[4] == COUNT_READING && avail(frame.avail_cnt, 7)) begin
        result.result_code   = RES_OK;
        result.reading_value = {b[6], b[7]};
        if (b[5] == SCALE_TEN_A || b[5] == SCALE_TEN_B) begin
          result.reading_scale = 2'd1;
        end else if (b[5] == SCALE_HUND_A || b[5] == SCALE_HUND_B) begin
          result.reading_scale = 2'd2;
        end
      end
    end else if (cmd == CMD_STATUS) begin
      if (b[4] == COUNT_STATUS && avail(frame.avail_cnt, 9)) begin
        result.result_code     = RES_OK;
        result.is_status_reply = 1'b1;
        result.status_bits     = {b[5], b[6], b[7], b[8], b[9]};
      end
    end else if (cmd == CMD_ONOFF) begin
      result.result_code = RES_OK;
    end
  end

endmodule

/* rtl/rfc_result_buf.sv */
module rfc_result_buf
  import rfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  rfc_result_t push_data,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output rfc_result_t out_data
);

  logic        skid_valid;
  rfc_result_t skid_data;
  logic        pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* rtl/reply_frame_checker.sv */
// Reply frame checker: takes a reply frame one byte per request on rx, with
// frame_end set on the closing checksum byte and the sent command code given
// with the first byte, and returns one result request per frame on result.
// A byte is taken every clock cycle that rx is ready; the checksum runs as a
// single 8-bit accumulator and the decode of the ten leading bytes is done in
// the end byte's cycle, so the result is written into the output register, or
// into the entry behind it while that register is held. One result may wait
// there, so rx keeps taking bytes while a result is stalled and stalls only
// when two results wait. unit_address (reset 1) is set via cfg_write_en and
// cfg_write_data; the user must write it only while no frame is in progress
// (not checked by the block). Frames over MaxFrameBytes bytes report invalid.
module reply_frame_checker
  import rfc_pkg::*;
#(
  parameter int MaxFrameBytes = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic [7:0]   cfg_write_data,
  rfc_rx_if.sink       rx,
  rfc_result_if.source result
);

  logic [7:0]  unit_addr_q;
  logic        accept;
  logic        space;
  rfc_frame_t  frame;
  rfc_result_t decoded;
  rfc_result_t out_data;

  // unit address register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_addr_q <= 8'd1;
    end else if (cfg_write_en) begin
      unit_addr_q <= cfg_write_data;
    end
  end

  assign rx.ready     = space;
  assign accept       = rx.valid && space;

  rfc_frame_track #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_track (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .rx_byte          (rx.rx_byte),
    .frame_end        (rx.frame_end),
    .expected_command (rx.expected_command),
    .frame            (frame)
  );

  rfc_decode u_decode (
    .frame        (frame),
    .rx_byte      (rx.rx_byte),
    .unit_address (unit_addr_q),
    .result       (decoded)
  );

  rfc_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && rx.frame_end),
    .push_data (decoded),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  // result payload
  assign result.result_code     = out_data.result_code;
  assign result.reading_value   = out_data.reading_value;
  assign result.reading_scale   = out_data.reading_scale;
  assign result.is_status_reply = out_data.is_status_reply;
  assign result.status_bits     = out_data.status_bits;

endmodule
